/* src/iva_pkg.sv */
`default_nettype none
package iva_pkg;

  localparam int MAP_SLOTS = 256;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = MAP_SLOTS / WORD_W;
  localparam int WSEL_W    = $clog2(NUM_WORDS);
  localparam int BSEL_W    = $clog2(WORD_W);
  localparam int VEC_W     = 8;
  localparam int OP_W      = 2;
  localparam int IN_DW     = 16;
  localparam int OUT_DW    = 16;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // request kinds
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // register map (byte addresses)
  localparam logic [CFG_AW-1:0] REG_SEARCH_START = 3'd0;

  localparam logic [VEC_W-1:0] SEARCH_START_RST = 8'd32;
  localparam int               SYSTEM_VECTORS   = 32;
  localparam int               RESV_SPURIOUS    = 8'hFF;
  localparam int               RESV_TIMER       = 8'hEF;
  localparam int               RESV_ERROR       = 8'hFE;

  typedef logic [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic load;    // transaction accepted: capture request, first search stage
    logic commit;  // finish request: update map, fill output register
  } iva_cmd_t;

  typedef struct packed {
    logic out_valid;
  } iva_sts_t;

  // map contents after reset, full 256-slot view
  function automatic logic [MAP_SLOTS-1:0] map_reset_value();
    logic [MAP_SLOTS-1:0] m;
    m = '0;
    for (int v = 0; v < SYSTEM_VECTORS; v++) m[v] = 1'b1;
    m[RESV_SPURIOUS] = 1'b1;
    m[RESV_TIMER]    = 1'b1;
    m[RESV_ERROR]    = 1'b1;
    return m;
  endfunction

endpackage
`default_nettype wire

/* src/iva_ctrl.sv */
`default_nettype none
module iva_ctrl
  import iva_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     out_tready,
  input  wire iva_sts_t sts,
  output iva_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   slot_free;

  assign in_tready = (state_r == ST_IDLE);
  assign slot_free = !sts.out_valid || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // wait here while the previous result sits untaken
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_BUSY))
    else $error("accepted request did not enter busy");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) && !slot_free |=> (state_r == ST_BUSY) && !in_tready)
    else $error("request dropped during output stall");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule
`default_nettype wire

/* src/iva_dp.sv */
`default_nettype none
module iva_dp
  import iva_pkg::*;
#(
  parameter int NUM_VECTORS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IN_DW-1:0]  in_tdata,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  input  wire iva_cmd_t          cmd,
  output iva_sts_t               sts
);

  localparam logic [MAP_SLOTS-1:0] MAP_RST_FULL = map_reset_value();
  localparam logic [NUM_VECTORS-1:0] MAP_RST = MAP_RST_FULL[NUM_VECTORS-1:0];

  logic [NUM_VECTORS-1:0] map_r, map_nxt;
  vec_t                   start_r;
  logic [OP_W-1:0]        op_r;
  vec_t                   vec_r;
  logic [NUM_WORDS-1:0]   wflag_r, wflag_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]      out_data_r;

  logic [MAP_SLOTS-1:0]   map_ext;
  logic [MAP_SLOTS-1:0]   cand;
  logic [WSEL_W-1:0]      word_sel;
  logic [WORD_W-1:0]      word_bits;
  logic [BSEL_W-1:0]      bit_sel;
  vec_t                   given;
  logic                   alloc_ok;
  logic                   used;
  logic                   cfg_wr;

  // config register
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_SEARCH_START);
  assign cfg_prdata = (cfg_paddr == REG_SEARCH_START) ? CFG_DW'(start_r) : '0;

  // full-size map view, slots beyond the map read as used-free zero but never candidates
  always_comb begin
    map_ext = '0;
    for (int i = 0; i < NUM_VECTORS; i++) map_ext[i] = map_r[i];
  end

  // free slots at or above the start
  always_comb begin
    cand = '0;
    for (int v = 0; v < NUM_VECTORS; v++) begin
      cand[v] = !map_r[v] && (VEC_W'(v) >= start_r);
    end
  end

  // stage 1: per-word "has a candidate" flags
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) wflag_nxt[w] = |cand[w*WORD_W +: WORD_W];
  end

  // stage 2: lowest flagged word, then lowest bit in it
  always_comb begin
    word_sel = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (wflag_r[w]) word_sel = WSEL_W'(w);
    end
    word_bits = cand[{word_sel, {BSEL_W{1'b0}}} +: WORD_W];
    bit_sel   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word_bits[b]) bit_sel = BSEL_W'(b);
    end
  end

  assign alloc_ok = (op_r == OP_ALLOC) && (|wflag_r);
  assign given    = alloc_ok ? {word_sel, bit_sel} : '0;
  assign used     = (op_r == OP_QUERY) && map_ext[vec_r];

  always_comb begin
    map_nxt = map_r;
    if (cmd.commit) begin
      for (int i = 0; i < NUM_VECTORS; i++) begin
        if (alloc_ok && (VEC_W'(i) == given)) map_nxt[i] = 1'b1;
        if ((op_r == OP_FREE) && (VEC_W'(i) == vec_r)) map_nxt[i] = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= MAP_RST;
      start_r     <= SEARCH_START_RST;
      out_valid_r <= 1'b0;
    end else begin
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) start_r <= cfg_pwdata[VEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tdata[OP_W-1:0];
      vec_r   <= in_tdata[OP_W +: VEC_W];
      wflag_r <= wflag_nxt;
    end
    if (cmd.commit) begin
      out_data_r <= {{(OUT_DW-VEC_W-2){1'b0}}, used, alloc_ok, given};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign sts.out_valid = out_valid_r;

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.commit) && out_data_r[VEC_W]
      |-> map_ext[out_data_r[VEC_W-1:0]])
    else $error("allocated vector not marked used");

  a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result missing from output register");

  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.commit) |-> !(out_data_r[VEC_W] && out_data_r[VEC_W+1]))
    else $error("alloc_ok and marked_used both set");

endmodule
`default_nettype wire

/* src/interrupt_vector_allocator.sv */
`default_nettype none
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid/in_tready     op, vector_in
// out_     master     out_tvalid/out_tready   vector_given, alloc_ok, marked_used
// cfg_     APB slave  psel/penable/pwrite     search_start at byte address 0
//
// Each request is loaded in its accept cycle, which reduces the free map to per-word flags; the
// commit, once the output register is free, picks the lowest word and bit, updates the map and
// loads the output register, whose valid rises in the cycle after the commit. One request is
// in flight at a time. A result waiting in the output register does not block acceptance;
// only its commit waits for the register to drain. Reset (synchronous, active low) loads
// the map with system vectors 0-31 and vectors 0xEF, 0xFE, 0xFF marked, search_start = 32.
module interrupt_vector_allocator
  import iva_pkg::*;
#(
  parameter int NUM_VECTORS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,    // [1:0] op, [9:2] vector_in, rest zero
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,   // [7:0] vector_given, [8] alloc_ok,
                                              // [9] marked_used, rest zero
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  iva_cmd_t cmd;
  iva_sts_t sts;

  assign cfg_pready = 1'b1;

  // sequencer: idle / busy, raises load on accept and commit when output is free
  iva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // map, two-stage first-free search, config register, output register
  iva_dp #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire

/* verif/interrupt_vector_allocator_tb.sv */
`default_nettype none
module interrupt_vector_allocator_tb
  import iva_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VEC = 256;
  // op 3 is not a request kind; the block must answer it with an all-zero result
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one result transaction, decoded from out_tdata
  typedef struct packed {
    vec_t vector_given;
    logic alloc_ok;
    logic marked_used;
  } alloc_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;     // [1:0] op, [9:2] vector_in
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;         // [7:0] vector_given, [8] alloc_ok, [9] marked_used
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the block: used/free map and the search floor
  logic [MAP_SLOTS-1:0] used_map;
  vec_t                 search_start_q;
  alloc_reply_t         pending_replies[$];

  // stimulus knobs
  bit tx_steady = 1'b0;   // sender never idles
  bit rx_steady = 1'b0;   // receiver never stalls
  int hold_cycles = 0;    // receiver holds off this many cycles, then clears it

  // bookkeeping for the summary
  int err_count = 0;
  int n_grants = 0;
  int n_exhausted = 0;
  int n_frees = 0;
  int n_queries = 0;
  int n_unused = 0;
  int n_cfg_writes = 0;

  interrupt_vector_allocator #(
    .NUM_VECTORS(NUM_VEC)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow map
  // ---------------------------------------------------------------------------

  // map after reset: system vectors 0-31 plus the three reserved ones, if they exist
  task automatic reset_model();
    used_map = '0;
    for (int i = 0; i < SYSTEM_VECTORS; i++)
      if (i < NUM_VEC) used_map[i] = 1'b1;
    if (RESV_SPURIOUS < NUM_VEC) used_map[RESV_SPURIOUS] = 1'b1;
    if (RESV_TIMER < NUM_VEC)    used_map[RESV_TIMER]    = 1'b1;
    if (RESV_ERROR < NUM_VEC)    used_map[RESV_ERROR]    = 1'b1;
    search_start_q = SEARCH_START_RST;
  endtask

  // apply one request to the shadow map and return the reply it must produce
  function automatic alloc_reply_t apply_request(input logic [OP_W-1:0] op, input vec_t vec);
    alloc_reply_t r;
    logic found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        // lowest free slot at or above the floor; a floor past the map finds nothing
        for (int i = 0; i < MAP_SLOTS; i++) begin
          if (!found && i >= search_start_q && i < NUM_VEC && !used_map[i]) begin
            found = 1'b1;
            used_map[i] = 1'b1;
            r.vector_given = vec_t'(i);
            r.alloc_ok = 1'b1;
          end
        end
        if (found) n_grants++;
        else n_exhausted++;
      end
      OP_FREE: begin
        // no protection for system or reserved vectors
        if (vec < NUM_VEC) used_map[vec] = 1'b0;
        n_frees++;
      end
      OP_QUERY: begin
        if (vec < NUM_VEC) r.marked_used = used_map[vec];
        n_queries++;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker and predictor: one process, so the order of check and push is fixed.
  // A result is registered only after its request is accepted, so the check of this edge
  // never needs the push of this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_predict
    alloc_reply_t want;
    if (!rst_n) begin
      reset_model();
      pending_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          err_count++;
          $error("result transaction with no request pending, out_tdata %h", out_tdata);
        end else begin
          want = pending_replies.pop_front();
          if (out_tdata[7:0] !== want.vector_given) begin
            err_count++;
            $error("vector_given: expected %0d, got %0d", want.vector_given, out_tdata[7:0]);
          end
          if (out_tdata[8] !== want.alloc_ok) begin
            err_count++;
            $error("alloc_ok: expected %0d, got %0d", want.alloc_ok, out_tdata[8]);
          end
          if (out_tdata[9] !== want.marked_used) begin
            err_count++;
            $error("marked_used: expected %0d, got %0d", want.marked_used, out_tdata[9]);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_SEARCH_START)
        search_start_q = cfg_pwdata[VEC_W-1:0];
      if (in_tvalid && in_tready)
        pending_replies.push_back(apply_request(in_tdata[OP_W-1:0],
                                                in_tdata[OP_W +: VEC_W]));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_tready = rx_steady || ($urandom_range(99) >= 33);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input vec_t vec);
    while (!tx_steady && $urandom_range(99) < 33) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {{(IN_DW - OP_W - VEC_W){1'b0}}, vec, op};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // sender pause: nothing outstanding once this returns
  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // APB write of the floor, then read it back; only while the block is idle
  task automatic write_search_start(input vec_t value);
    wait_for_drain();
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = REG_SEARCH_START;
    cfg_pwdata = {{(CFG_DW - VEC_W){1'b0}}, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    n_cfg_writes++;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[VEC_W-1:0] !== value) begin
      err_count++;
      $error("search_start: expected %0d, got %0d", value, cfg_prdata[VEC_W-1:0]);
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset contents: edges of the system block and each reserved vector
  task automatic test_reset_map();
    send_request(OP_QUERY, 8'd0);
    send_request(OP_QUERY, 8'd31);
    send_request(OP_QUERY, 8'd32);
    send_request(OP_QUERY, 8'hEE);
    send_request(OP_QUERY, vec_t'(RESV_TIMER));
    send_request(OP_QUERY, 8'hFD);
    send_request(OP_QUERY, vec_t'(RESV_ERROR));
    send_request(OP_QUERY, vec_t'(RESV_SPURIOUS));
    send_request(OP_UNUSED, 8'hFF);    // unused kind: no effect, zero reply
  endtask

  // allocation around the floor, frees of reserved/system/free vectors, exhaustion
  task automatic test_alloc_edges();
    send_request(OP_ALLOC, 8'hFF);     // vector_in ignored on allocate
    send_request(OP_ALLOC, 8'h00);
    send_request(OP_FREE, 8'd32);
    send_request(OP_FREE, 8'd32);      // freeing an already free vector
    send_request(OP_QUERY, 8'd32);
    send_request(OP_ALLOC, 8'h5A);
    send_request(OP_FREE, vec_t'(RESV_SPURIOUS));
    write_search_start(8'd255);        // top extreme
    send_request(OP_ALLOC, 8'h00);     // hands out the freed spurious vector
    send_request(OP_ALLOC, 8'h00);     // nothing left above the floor
    write_search_start(8'd0);          // bottom extreme
    send_request(OP_FREE, 8'd5);       // system vector freed
    send_request(OP_ALLOC, 8'h00);
    write_search_start(vec_t'(RESV_TIMER));
    send_request(OP_ALLOC, 8'h00);     // skips the timer vector
    write_search_start(SEARCH_START_RST);
  endtask

  // each phase either fills or drains the map, under different floors
  task automatic test_random_traffic();
    int   floors[10];
    bit   filling[10];
    int   lengths[10];
    int   pick;
    logic [OP_W-1:0] op;
    vec_t vec;
    floors  = '{32, 0, 128, 0, 0, 240, 255, -1, 0, 32};
    filling = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 1};
    lengths = '{70, 70, 60, 70, 60, 30, 40, 60, 60, 40};
    for (int p = 0; p < 10; p++) begin
      write_search_start(floors[p] < 0 ? vec_t'($urandom_range(255)) : vec_t'(floors[p]));
      // one phase with neither side idling
      tx_steady = (p == 2);
      rx_steady = (p == 2);
      for (int n = 0; n < lengths[p]; n++) begin
        pick = $urandom_range(99);
        if (filling[p])
          op = (pick < 70) ? OP_ALLOC : (pick < 85) ? OP_FREE :
               (pick < 97) ? OP_QUERY : OP_UNUSED;
        else
          op = (pick < 25) ? OP_ALLOC : (pick < 80) ? OP_FREE :
               (pick < 97) ? OP_QUERY : OP_UNUSED;
        // frees and queries lean toward the allocatable range
        if ($urandom_range(99) < 60)
          vec = vec_t'($urandom_range(255, search_start_q));
        else
          vec = vec_t'($urandom_range(255));
        send_request(op, vec);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // long receiver hold-off while the sender keeps offering: input must stall
  task automatic test_backpressure();
    wait_for_drain();
    hold_cycles = 80;
    for (int n = 0; n < 12; n++)
      send_request(($urandom_range(1) != 0) ? OP_ALLOC : OP_QUERY,
                   vec_t'($urandom_range(255)));
  endtask

  // sender stops until every reply is back, then resumes
  task automatic test_drain_pause();
    for (int n = 0; n < 8; n++) send_request(OP_ALLOC, vec_t'($urandom_range(255)));
    wait_for_drain();
    for (int n = 0; n < 8; n++) send_request(OP_FREE, vec_t'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int guard;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_reset_map();
    test_alloc_edges();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    in_tvalid = 1'b0;

    // wait out the replies still in flight, bounded
    guard = 0;
    while (pending_replies.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);   // catch stray extra results
    if (pending_replies.size() != 0) begin
      err_count++;
      $error("%0d replies never arrived", pending_replies.size());
    end

    $display("covered %0d requests: %0d grants, %0d exhausted allocations, %0d frees,",
             n_grants + n_exhausted + n_frees + n_queries + n_unused,
             n_grants, n_exhausted, n_frees);
    $display("  %0d queries, %0d unused-kind requests, %0d search_start writes (0 and 255 incl.)",
             n_queries, n_unused, n_cfg_writes);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
